// ===== sv/lprf_pkg.sv =====
// ----------------------------------------------------------------------------
// lprf_pkg
// Shared types and codes for the length-prefixed record FIFO.
// ----------------------------------------------------------------------------
package lprf_pkg;

  localparam int unsigned CountW = 11;  // width of the reported counters

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_PUT   = 2'd1,
    OP_GET   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_SEQ      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_LEN,
    S_RD_DATA
  } state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] record_length;
    logic [7:0] data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        read_byte;
    logic              read_valid;
    logic              record_end;
    logic [7:0]        read_length;
    logic [CountW-1:0] records_held;
    logic [CountW-1:0] free_bytes;
  } rsp_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ===== sv/lprf_store.sv =====
// ----------------------------------------------------------------------------
// lprf_store
// Single-ported byte store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module lprf_store
  import lprf_pkg::*;
#(
  parameter int unsigned Depth = 1024,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  mem_ctl_t         ctl_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/length_prefixed_record_fifo.sv =====
// Begin and payload writes, empty and rejected requests: result in the cycle after
// acceptance. A read inside an open record: store read, then result register. A
// read that opens a record: length byte, then payload byte (none if the record is
// empty), then result register. Writes one per cycle unless a read holds busy_o high.
// Reset: asynchronous; pointers and counts cleared, all space free, store untouched.
// Results are strobed for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// length_prefixed_record_fifo
// Byte ring buffer of length-prefixed records: reserve, fill, read back.
// ----------------------------------------------------------------------------
module length_prefixed_record_fifo
  import lprf_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  req_t req_i,
  output logic busy_o,
  output logic done_o,
  output rsp_t rsp_o
);

  localparam int unsigned PtrW = $clog2(BUFFER_BYTES);
  localparam int unsigned CntW = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned CmpW = (CntW > 9) ? CntW : 9;
  localparam logic [PtrW-1:0] LastPtr = PtrW'(BUFFER_BYTES - 1);

  state_e          state_q, state_d;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] rec_cnt_q, rec_cnt_d;
  logic [CntW-1:0] free_q, free_d;
  logic [7:0]      wr_rem_q, wr_rem_d;
  logic [7:0]      rd_rem_q, rd_rem_d;
  logic [7:0]      rd_len_q, rd_len_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  mem_ctl_t        mem_ctl;
  logic [PtrW-1:0] mem_addr;
  logic [7:0]      mem_wdata;
  logic [7:0]      mem_rdata;

  logic            emit;
  status_e         res_status;
  logic [7:0]      res_byte;
  logic            res_valid;
  logic            res_end;
  logic            room_ok;
  logic            get_waits;

  lprf_store #(
    .Depth (BUFFER_BYTES),
    .AddrW (PtrW)
  ) u_store (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == LastPtr) ? '0 : p + PtrW'(1);
  endfunction

  assign room_ok = CmpW'(free_q) >= (CmpW'(req_i.record_length) + CmpW'(1));
  // a read that has a byte to fetch from the store
  assign get_waits = (rd_rem_q != '0) || (rec_cnt_q != '0);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && (req_i.operation == OP_GET) && get_waits) begin
          state_d = (rd_rem_q == '0) ? S_RD_LEN : S_RD_DATA;
        end
      end
      S_RD_LEN: begin
        state_d = (mem_rdata == '0) ? S_IDLE : S_RD_DATA;
      end
      S_RD_DATA: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and store access
  always_comb begin
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    rec_cnt_d  = rec_cnt_q;
    free_d     = free_q;
    wr_rem_d   = wr_rem_q;
    rd_rem_d   = rd_rem_q;
    rd_len_d   = rd_len_q;
    mem_ctl    = '0;
    mem_addr   = rd_ptr_q;
    mem_wdata  = req_i.data_byte;
    emit       = 1'b0;
    res_status = ST_OK;
    res_byte   = '0;
    res_valid  = 1'b0;
    res_end    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (req_i.operation)
            OP_BEGIN: begin
              emit = 1'b1;
              if (wr_rem_q != '0) begin
                res_status = ST_SEQ;
              end else if (!room_ok) begin
                res_status = ST_NO_SPACE;
              end else begin
                free_d     = CntW'(CmpW'(free_q) - CmpW'(req_i.record_length) - CmpW'(1));
                mem_ctl.we = 1'b1;
                mem_addr   = wr_ptr_q;
                mem_wdata  = req_i.record_length;
                wr_ptr_d   = ptr_next(wr_ptr_q);
                if (req_i.record_length == '0) begin
                  rec_cnt_d = rec_cnt_q + CntW'(1);
                end else begin
                  wr_rem_d = req_i.record_length;
                end
              end
            end
            OP_PUT: begin
              emit = 1'b1;
              if (wr_rem_q == '0) begin
                res_status = ST_SEQ;
              end else begin
                mem_ctl.we = 1'b1;
                mem_addr   = wr_ptr_q;
                wr_ptr_d   = ptr_next(wr_ptr_q);
                wr_rem_d   = wr_rem_q - 8'd1;
                if (wr_rem_q == 8'd1) begin
                  rec_cnt_d = rec_cnt_q + CntW'(1);
                end
              end
            end
            OP_GET: begin
              if (!get_waits) begin
                emit       = 1'b1;
                res_status = ST_EMPTY;
              end else begin
                // length byte or payload byte, result once it returns
                mem_ctl.re = 1'b1;
                rd_ptr_d   = ptr_next(rd_ptr_q);
                free_d     = free_q + CntW'(1);
              end
            end
            default: begin
              emit       = 1'b1;
              res_status = ST_SEQ;
            end
          endcase
        end
      end
      S_RD_LEN: begin
        rd_len_d = mem_rdata;
        if (mem_rdata == '0) begin
          emit      = 1'b1;
          res_end   = 1'b1;
          rec_cnt_d = rec_cnt_q - CntW'(1);
        end else begin
          mem_ctl.re = 1'b1;
          rd_ptr_d   = ptr_next(rd_ptr_q);
          free_d     = free_q + CntW'(1);
          rd_rem_d   = mem_rdata;
        end
      end
      S_RD_DATA: begin
        emit      = 1'b1;
        res_byte  = mem_rdata;
        res_valid = 1'b1;
        rd_rem_d  = rd_rem_q - 8'd1;
        if (rd_rem_q == 8'd1) begin
          res_end   = 1'b1;
          rec_cnt_d = rec_cnt_q - CntW'(1);
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase

    done_d = emit;
    rsp_d  = rsp_q;
    if (emit) begin
      rsp_d.status       = res_status;
      rsp_d.read_byte    = res_byte;
      rsp_d.read_valid   = res_valid;
      rsp_d.record_end   = res_end;
      rsp_d.read_length  = rd_len_d;
      rsp_d.records_held = CountW'(rec_cnt_d);
      rsp_d.free_bytes   = CountW'(free_d);
    end
  end

  // outputs
  always_comb begin
    busy_o = (state_q != S_IDLE);
    done_o = done_q;
    rsp_o  = rsp_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      wr_ptr_q  <= '0;
      rd_ptr_q  <= '0;
      rec_cnt_q <= '0;
      free_q    <= CntW'(BUFFER_BYTES);
      wr_rem_q  <= '0;
      rd_rem_q  <= '0;
      rd_len_q  <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      wr_ptr_q  <= wr_ptr_d;
      rd_ptr_q  <= rd_ptr_d;
      rec_cnt_q <= rec_cnt_d;
      free_q    <= free_d;
      wr_rem_q  <= wr_rem_d;
      rd_rem_q  <= rd_rem_d;
      rd_len_q  <= rd_len_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

endmodule

// ===== sv/lprf_checker.sv =====
// ----------------------------------------------------------------------------
// lprf_checker
// Port-level checks for the record FIFO, bound to the top level.
// ----------------------------------------------------------------------------
module lprf_checker
  import lprf_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input req_t req_i,
  input logic busy_o,
  input logic done_o,
  input rsp_t rsp_o
);

  // writes and rejected requests answer in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o && (req_i.operation != OP_GET) |=> done_o && !busy_o)
    else $error("write request not answered in one cycle");

  // a read finishing its work always leaves a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> done_o)
    else $error("busy dropped without a result");

  // a result needs a request behind it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o) || $past(start_i))
    else $error("result without request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.read_valid |-> rsp_o.status == ST_OK)
    else $error("payload byte with bad status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == ST_EMPTY) |->
      (rsp_o.records_held == '0) && !rsp_o.read_valid && !rsp_o.record_end)
    else $error("empty status while records held");

endmodule

bind length_prefixed_record_fifo lprf_checker u_lprf_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the length-prefixed record FIFO. A short table of
// directed requests is followed by random fill and drain passes. Every
// accepted request is run through a behavioral copy of the buffer. Each
// strobed result is compared field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lprf_pkg::*;

  localparam int unsigned BufferBytes    = 1024;
  localparam int unsigned PtrBits        = $clog2(BufferBytes);
  localparam int unsigned RandomRequests = 1850;
  localparam int unsigned DirectedRows   = 15;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned DrainCycles    = 8;
  localparam logic [1:0]  OpUnused       = 2'd3;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  req_t req_i;
  logic busy_o;
  logic done_o;
  rsp_t rsp_o;

  length_prefixed_record_fifo #(
    .BUFFER_BYTES(BufferBytes)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .req_i  (req_i),
    .busy_o (busy_o),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the buffer
  logic [7:0]  shadow_mem [BufferBytes];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  int unsigned rec_count = 0;
  int unsigned free_count = BufferBytes;
  int unsigned wr_left = 0;
  bit          wr_open = 1'b0;
  int unsigned rd_left = 0;
  logic [7:0]  rd_len = '0;

  rsp_t        awaited_rsp [$];
  bit          row_typed = 1'b0;
  rsp_t        row_want;
  int unsigned failures = 0;
  int unsigned accepted = 0;
  int unsigned checked = 0;
  int unsigned bytes_read = 0;
  int unsigned records_read = 0;
  int unsigned refusals = 0;
  int unsigned refusal_mark = 0;
  int unsigned full_passes = 0;
  bit          fill_mode = 1'b1;
  int unsigned burst_left = 0;
  int unsigned cycles = 0;

  function automatic logic [7:0] take_byte();
    logic [7:0] v;
    v = shadow_mem[PtrBits'(rd_ptr)];
    rd_ptr = (rd_ptr + 1) % BufferBytes;
    free_count++;
    return v;
  endfunction

  function automatic void put_byte(logic [7:0] v);
    shadow_mem[PtrBits'(wr_ptr)] = v;
    wr_ptr = (wr_ptr + 1) % BufferBytes;
  endfunction

  // Advances the shadow buffer by one request and returns its result
  function automatic rsp_t record_fifo_step(req_t r);
    rsp_t o;
    bit   have;
    o = '0;
    o.status = ST_OK;
    case (r.operation)
      OP_BEGIN: begin
        if (wr_open) begin
          o.status = ST_SEQ;
        end else if (free_count < int'(r.record_length) + 1) begin
          o.status = ST_NO_SPACE;
          refusals++;
        end else begin
          free_count -= int'(r.record_length) + 1;
          put_byte(r.record_length);
          if (r.record_length == 0) begin
            rec_count++;
          end else begin
            wr_left = 32'(r.record_length);
            wr_open = 1'b1;
          end
        end
      end
      OP_PUT: begin
        if (!wr_open) begin
          o.status = ST_SEQ;
        end else begin
          put_byte(r.data_byte);
          wr_left--;
          if (wr_left == 0) begin
            wr_open = 1'b0;
            rec_count++;
          end
        end
      end
      OP_GET: begin
        have = 1'b1;
        if (rd_left == 0) begin
          if (rec_count == 0) begin
            o.status = ST_EMPTY;
            have = 1'b0;
          end else begin
            rd_len = take_byte();
            rd_left = 32'(rd_len);
            if (rd_left == 0) begin
              // zero-length record: done as soon as it is opened
              o.record_end = 1'b1;
              rec_count--;
              records_read++;
              have = 1'b0;
            end
          end
        end
        if (have) begin
          o.read_byte = take_byte();
          o.read_valid = 1'b1;
          bytes_read++;
          rd_left--;
          if (rd_left == 0) begin
            o.record_end = 1'b1;
            rec_count--;
            records_read++;
          end
        end
      end
      default: o.status = ST_SEQ;
    endcase
    o.read_length = rd_len;
    o.records_held = CountW'(rec_count);
    o.free_bytes = CountW'(free_count);
    return o;
  endfunction

  function automatic req_t mk_req(logic [1:0] op, logic [7:0] len, logic [7:0] dat);
    req_t r;
    r.operation = op;
    r.record_length = len;
    r.data_byte = dat;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(status_e st, logic [7:0] rb, logic v, logic e,
                                  logic [7:0] len, int unsigned held, int unsigned free);
    rsp_t o;
    o.status = st;
    o.read_byte = rb;
    o.read_valid = v;
    o.record_end = e;
    o.read_length = len;
    o.records_held = CountW'(held);
    o.free_bytes = CountW'(free);
    return o;
  endfunction

  // Mostly well-formed records; fill until space runs out, then drain to empty
  function automatic req_t next_random_request();
    req_t        r;
    int unsigned roll;
    r.data_byte = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 55) r.record_length = 8'($urandom_range(15));
    else if (roll < 85) r.record_length = 8'($urandom_range(16, 254));
    else r.record_length = 8'd255;
    if (fill_mode && refusals >= refusal_mark + 3) begin
      fill_mode = 1'b0;
      full_passes++;
    end else if (!fill_mode && rec_count == 0 && rd_left == 0) begin
      fill_mode = 1'b1;
      refusal_mark = refusals;
    end
    if ($urandom_range(99) < 5) begin
      r.operation = 2'($urandom_range(3));
    end else if ($urandom_range(99) < (fill_mode ? 88 : 22)) begin
      r.operation = wr_open ? OP_PUT : OP_BEGIN;
    end else begin
      r.operation = OP_GET;
    end
    return r;
  endfunction

  task automatic check_rsp(rsp_t want, rsp_t got);
    if (got.status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, got.status);
      failures++;
    end
    if (got.read_byte !== want.read_byte) begin
      $error("read_byte: expected %0h, got %0h", want.read_byte, got.read_byte);
      failures++;
    end
    if (got.read_valid !== want.read_valid) begin
      $error("read_valid: expected %0b, got %0b", want.read_valid, got.read_valid);
      failures++;
    end
    if (got.record_end !== want.record_end) begin
      $error("record_end: expected %0b, got %0b", want.record_end, got.record_end);
      failures++;
    end
    if (got.read_length !== want.read_length) begin
      $error("read_length: expected %0d, got %0d", want.read_length, got.read_length);
      failures++;
    end
    if (got.records_held !== want.records_held) begin
      $error("records_held: expected %0d, got %0d", want.records_held, got.records_held);
      failures++;
    end
    if (got.free_bytes !== want.free_bytes) begin
      $error("free_bytes: expected %0d, got %0d", want.free_bytes, got.free_bytes);
      failures++;
    end
  endtask

  // Results are checked before this edge's request is predicted
  always @(posedge clk_i) begin
    rsp_t predicted;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_rsp.size() == 0) begin
          $error("result strobed with no request outstanding");
          failures++;
        end else begin
          check_rsp(awaited_rsp.pop_front(), rsp_o);
          checked++;
        end
      end
      if (start_i && !busy_o) begin
        predicted = record_fifo_step(req_i);
        awaited_rsp.push_back(row_typed ? row_want : predicted);
        accepted++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("length_prefixed_record_fifo: mismatch");
      $finish;
    end
  end

  task automatic send_request(input bit from_table, input stim_row_t row);
    req_t r;
    @(negedge clk_i);
    if (from_table) begin
      r = row.req;
      row_typed = row.typed;
      row_want = row.want;
    end else begin
      r = next_random_request();
      row_typed = 1'b0;
    end
    start_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic pace();
    int unsigned idle_for;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      idle_for = $urandom_range(1, 6);
      @(negedge clk_i);
      start_i <= 1'b0;
      repeat (idle_for - 1) @(negedge clk_i);
      burst_left = ($urandom_range(9) == 0) ? $urandom_range(60, 150) : $urandom_range(12);
    end
  endtask

  stim_row_t directed_rows [DirectedRows];

  initial begin
    stim_row_t no_row;
    start_i = 1'b0;
    req_i = '0;
    rst_ni = 1'b0;
    row_want = '0;
    no_row = '{req: '0, typed: 1'b0, want: '0};
    directed_rows = '{
      '{mk_req(OP_GET, 8'd0, 8'd0), 1'b1,
        mk_rsp(ST_EMPTY, 8'h00, 1'b0, 1'b0, 8'd0, 0, 1024)},
      '{mk_req(OP_PUT, 8'd0, 8'h3C), 1'b1,
        mk_rsp(ST_SEQ, 8'h00, 1'b0, 1'b0, 8'd0, 0, 1024)},
      '{mk_req(OpUnused, 8'hFF, 8'hFF), 1'b1,
        mk_rsp(ST_SEQ, 8'h00, 1'b0, 1'b0, 8'd0, 0, 1024)},
      '{mk_req(OP_BEGIN, 8'd0, 8'h00), 1'b1,
        mk_rsp(ST_OK, 8'h00, 1'b0, 1'b0, 8'd0, 1, 1023)},
      '{mk_req(OP_GET, 8'd0, 8'h00), 1'b1,
        mk_rsp(ST_OK, 8'h00, 1'b0, 1'b1, 8'd0, 0, 1024)},
      '{mk_req(OP_BEGIN, 8'd2, 8'h00), 1'b1,
        mk_rsp(ST_OK, 8'h00, 1'b0, 1'b0, 8'd0, 0, 1021)},
      '{mk_req(OP_PUT, 8'd0, 8'h00), 1'b0, '0},
      '{mk_req(OP_BEGIN, 8'd7, 8'h00), 1'b1,
        mk_rsp(ST_SEQ, 8'h00, 1'b0, 1'b0, 8'd0, 0, 1021)},
      '{mk_req(OP_GET, 8'd0, 8'h00), 1'b1,
        mk_rsp(ST_EMPTY, 8'h00, 1'b0, 1'b0, 8'd0, 0, 1021)},
      '{mk_req(OP_PUT, 8'd0, 8'hFF), 1'b1,
        mk_rsp(ST_OK, 8'h00, 1'b0, 1'b0, 8'd0, 1, 1021)},
      '{mk_req(OP_GET, 8'd0, 8'h00), 1'b1,
        mk_rsp(ST_OK, 8'h00, 1'b1, 1'b0, 8'd2, 1, 1023)},
      '{mk_req(OP_GET, 8'd0, 8'h00), 1'b1,
        mk_rsp(ST_OK, 8'hFF, 1'b1, 1'b1, 8'd2, 0, 1024)},
      '{mk_req(OP_BEGIN, 8'd255, 8'h00), 1'b1,
        mk_rsp(ST_OK, 8'h00, 1'b0, 1'b0, 8'd2, 0, 768)},
      '{mk_req(OP_PUT, 8'd0, 8'h81), 1'b0, '0},
      '{mk_req(OP_PUT, 8'd0, 8'h7E), 1'b0, '0}
    };

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      send_request(1'b1, directed_rows[i]);
      pace();
    end
    // the long record left open above is finished by the random stream
    repeat (RandomRequests) begin
      send_request(1'b0, no_row);
      pace();
    end
    @(negedge clk_i);
    start_i <= 1'b0;

    while (awaited_rsp.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d requests accepted, %0d results checked; %0d payload bytes in %0d records read",
             accepted, checked, bytes_read, records_read);
    $display("%0d begin requests refused for space over %0d runs to a full buffer",
             refusals, full_passes);
    if (failures == 0) begin
      $display("length_prefixed_record_fifo: match");
    end else begin
      $display("length_prefixed_record_fifo: mismatch");
    end
    $finish;
  end

endmodule
